>>> sv/strict_json_stream_validator_top_macros.svh
// Assertion helpers for the validator's output buffer module (sjv_out)
`ifndef STRICT_JSON_STREAM_VALIDATOR_TOP_MACROS_SVH
`define STRICT_JSON_STREAM_VALIDATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SJV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sjv assertion failed");

// Next-cycle implication, checked outside reset
`define SJV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sjv assertion failed");

`endif

>>> sv/sjv_pkg.sv
package sjv_pkg;

  localparam int MAX_RES = 5;

  // Event codes
  localparam logic [3:0] EV_OBJ_OPEN  = 4'd0;
  localparam logic [3:0] EV_OBJ_CLOSE = 4'd1;
  localparam logic [3:0] EV_ARR_OPEN  = 4'd2;
  localparam logic [3:0] EV_ARR_CLOSE = 4'd3;
  localparam logic [3:0] EV_KEY_BYTE  = 4'd4;
  localparam logic [3:0] EV_KEY_END   = 4'd5;
  localparam logic [3:0] EV_STR_BYTE  = 4'd6;
  localparam logic [3:0] EV_STR_END   = 4'd7;
  localparam logic [3:0] EV_NUM_CHAR  = 4'd8;
  localparam logic [3:0] EV_NUM_END   = 4'd9;
  localparam logic [3:0] EV_TRUE      = 4'd10;
  localparam logic [3:0] EV_FALSE     = 4'd11;
  localparam logic [3:0] EV_NULL      = 4'd12;
  localparam logic [3:0] EV_DONE      = 4'd13;
  localparam logic [3:0] EV_ERROR     = 4'd14;

  // Grammar modes
  localparam logic [4:0] M_BOM       = 5'd0;
  localparam logic [4:0] M_VALUE     = 5'd1;
  localparam logic [4:0] M_ARR_FIRST = 5'd2;
  localparam logic [4:0] M_OBJ_FIRST = 5'd3;
  localparam logic [4:0] M_KEY_EXP   = 5'd4;
  localparam logic [4:0] M_COLON     = 5'd5;
  localparam logic [4:0] M_AFTER     = 5'd6;
  localparam logic [4:0] M_ERR       = 5'd7;
  localparam logic [4:0] M_NSIGN     = 5'd8;
  localparam logic [4:0] M_NZERO     = 5'd9;
  localparam logic [4:0] M_NINT      = 5'd10;
  localparam logic [4:0] M_NFRAC0    = 5'd11;
  localparam logic [4:0] M_NFRAC     = 5'd12;
  localparam logic [4:0] M_NEXP0     = 5'd13;
  localparam logic [4:0] M_NEXPSIGN  = 5'd14;
  localparam logic [4:0] M_NEXP      = 5'd15;
  localparam logic [4:0] M_TRUE      = 5'd16;
  localparam logic [4:0] M_FALSE     = 5'd17;
  localparam logic [4:0] M_NULL      = 5'd18;
  localparam logic [4:0] M_SCH       = 5'd20;
  localparam logic [4:0] M_SESC      = 5'd21;
  localparam logic [4:0] M_SHEX      = 5'd22;
  localparam logic [4:0] M_SLOW      = 5'd23;
  localparam logic [4:0] M_KCH       = 5'd24;
  localparam logic [4:0] M_KESC      = 5'd25;
  localparam logic [4:0] M_KHEX      = 5'd26;
  localparam logic [4:0] M_KLOW      = 5'd27;

  // Configuration register indexes
  localparam logic [0:0] CFG_MAX_DEPTH = 1'd0;
  localparam logic [0:0] CFG_MAX_NLEN  = 1'd1;

  // Results caused by one input byte
  typedef struct packed {
    logic [MAX_RES-1:0][3:0] ev;
    logic [MAX_RES-1:0][7:0] data;
    logic [2:0]              cnt;
    logic [15:0]             line;
  } bundle_t;

  // Scratch grammar state of fixed width
  typedef struct packed {
    logic [4:0]  mode;
    logic [15:0] hex;
    logic [9:0]  pend;
    logic [2:0]  hcnt;
    logic [5:0]  nlen;
    logic [2:0]  lpos;
    logic [1:0]  bom;
  } gst_t;

  localparam gst_t GST_RESET = '{mode: M_BOM, hex: '0, pend: '0, hcnt: '0,
                                 nlen: '0, lpos: '0, bom: '0};

  // Append one result, dropping it when the bundle is full
  function automatic bundle_t add_ev(bundle_t b, logic [3:0] ev, logic [7:0] d);
    bundle_t r;
    r = b;
    if (int'(b.cnt) < MAX_RES) begin
      r.ev[b.cnt]   = ev;
      r.data[b.cnt] = d;
      r.cnt         = b.cnt + 3'd1;
    end
    return r;
  endfunction

  // Hex digit value, 16 when the byte is no hex digit
  function automatic logic [4:0] hex_of(logic [7:0] c);
    logic [4:0] r;
    r = 5'd16;
    if (c >= "0" && c <= "9") r = 5'(c - "0");
    else if (c >= "a" && c <= "f") r = 5'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") r = 5'(c - "A" + 8'd10);
    return r;
  endfunction

  // Expected character of a literal word at a position
  function automatic logic [7:0] lit_char(logic [4:0] mode, logic [2:0] pos);
    logic [7:0] r;
    r = 8'd0;
    if (mode == M_TRUE) begin
      case (pos)
        3'd0: r = "t";
        3'd1: r = "r";
        3'd2: r = "u";
        3'd3: r = "e";
        default: r = 8'd0;
      endcase
    end else if (mode == M_FALSE) begin
      case (pos)
        3'd0: r = "f";
        3'd1: r = "a";
        3'd2: r = "l";
        3'd3: r = "s";
        3'd4: r = "e";
        default: r = 8'd0;
      endcase
    end else begin
      case (pos)
        3'd0: r = "n";
        3'd1: r = "u";
        3'd2: r = "l";
        3'd3: r = "l";
        default: r = 8'd0;
      endcase
    end
    return r;
  endfunction

endpackage

>>> sv/sjv_ram.sv
module sjv_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/sjv_core.sv
module sjv_core #(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_BITS   = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      byte_value,
  input  logic            end_of_text,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_idx,
  input  logic [6:0]      cfg_wdata,
  output sjv_pkg::bundle_t bundle
);
  import sjv_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int CW = (DW > 7 ? DW : 7) + 1;
  localparam logic [LINE_BITS-1:0] LINE_TOP = '1;

  gst_t                 st_r, st_nxt;
  logic [DW-1:0]        dep_r, dep_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [6:0]           maxd_r;
  logic [5:0]           maxn_r;
  logic                 byp_r, bkind_r;
  logic                 ram_rd;
  logic                 top_kind;
  logic                 push;
  logic                 push_kind;
  logic [AW-1:0]        raddr;
  logic [DW-1:0]        rdep;
  logic [CW-1:0]        lim;
  bundle_t              b;

  // Container-kind stack, top entry read ahead from the next depth
  sjv_ram #(.WIDTH(1), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (accept && push),
    .waddr (dep_r[AW-1:0]),
    .wdata (push_kind),
    .raddr (raddr),
    .rdata (ram_rd)
  );

  assign top_kind = byp_r ? bkind_r : ram_rd;
  assign rdep     = (accept ? dep_nxt : dep_r) - DW'(1);
  assign raddr    = rdep[AW-1:0];
  assign lim      = (CW'(maxd_r) < CW'(STACK_DEPTH)) ? CW'(maxd_r) : CW'(STACK_DEPTH);

  // Grammar step for one byte
  always_comb begin
    gst_t          s;
    logic [DW-1:0] dep;
    logic [LINE_BITS-1:0] ln;
    logic [47:0]   lw;
    logic [7:0]    c;
    logic          ws, dig, ee, kmode;
    logic [4:0]    hv, base, num_next;
    logic [3:0]    sev;
    logic [15:0]   hx;
    logic [20:0]   cp;
    logic [2:0]    llen;
    logic          do_fail, do_ws, go_start, go_num, go_after, go_close, close_kind;
    logic          go_utf;

    s = st_r; dep = dep_r; ln = line_r; b = '0;
    c = byte_value;
    ws = (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    dig = (c >= "0") && (c <= "9");
    ee = (c == "e") || (c == "E");
    kmode = (st_r.mode >= M_KCH);
    base = kmode ? M_KCH : M_SCH;
    sev = kmode ? EV_KEY_BYTE : EV_STR_BYTE;
    hv = hex_of(c);
    hx = {st_r.hex[11:0], hv[3:0]};
    cp = '0;
    llen = (st_r.mode == M_FALSE) ? 3'd5 : 3'd4;
    num_next = M_NINT;
    do_fail = 1'b0; do_ws = 1'b0; go_start = 1'b0; go_num = 1'b0;
    go_after = 1'b0; go_close = 1'b0; close_kind = 1'b0; go_utf = 1'b0;
    push = 1'b0; push_kind = (c == "{");

    if (st_r.mode != M_ERR) begin
      unique case (st_r.mode) inside
        M_BOM: begin
          if (st_r.bom == 2'd0) begin
            if (c == 8'hEF) s.bom = 2'd1;
            else begin
              s.mode = M_VALUE;
              if (ws) do_ws = 1'b1; else go_start = 1'b1;
            end
          end else if (st_r.bom == 2'd1) begin
            if (c == 8'hBB) s.bom = 2'd2; else do_fail = 1'b1;
          end else begin
            if (c == 8'hBF) begin
              s.bom = 2'd0; s.mode = M_VALUE;
            end else do_fail = 1'b1;
          end
        end
        M_VALUE: begin
          if (ws) do_ws = 1'b1; else go_start = 1'b1;
        end
        M_ARR_FIRST: begin
          if (ws) do_ws = 1'b1;
          else if (c == "]") begin
            go_close = 1'b1; close_kind = 1'b0;
          end else go_start = 1'b1;
        end
        M_OBJ_FIRST, M_KEY_EXP: begin
          if (ws) do_ws = 1'b1;
          else if (c == "}" && st_r.mode == M_OBJ_FIRST) begin
            go_close = 1'b1; close_kind = 1'b1;
          end else if (c == "\"") s.mode = M_KCH;
          else do_fail = 1'b1;
        end
        M_COLON: begin
          if (ws) do_ws = 1'b1;
          else if (c == ":" && (CW'(dep_r) + CW'(1)) <= lim) s.mode = M_VALUE;
          else do_fail = 1'b1;
        end
        M_AFTER: go_after = 1'b1;
        M_NSIGN: begin
          if (c == "0") begin go_num = 1'b1; num_next = M_NZERO; end
          else if (dig) begin go_num = 1'b1; num_next = M_NINT; end
          else do_fail = 1'b1;
        end
        M_NZERO, M_NINT: begin
          if (st_r.mode == M_NINT && dig) begin go_num = 1'b1; num_next = M_NINT; end
          else if (c == ".") begin go_num = 1'b1; num_next = M_NFRAC0; end
          else if (ee) begin go_num = 1'b1; num_next = M_NEXP0; end
          else begin
            b = add_ev(b, EV_NUM_END, 8'd0); s.mode = M_AFTER; go_after = 1'b1;
          end
        end
        M_NFRAC0: begin
          if (dig) begin go_num = 1'b1; num_next = M_NFRAC; end
          else do_fail = 1'b1;
        end
        M_NFRAC: begin
          if (dig) begin go_num = 1'b1; num_next = M_NFRAC; end
          else if (ee) begin go_num = 1'b1; num_next = M_NEXP0; end
          else begin
            b = add_ev(b, EV_NUM_END, 8'd0); s.mode = M_AFTER; go_after = 1'b1;
          end
        end
        M_NEXP0: begin
          if (c == "+" || c == "-") begin go_num = 1'b1; num_next = M_NEXPSIGN; end
          else if (dig) begin go_num = 1'b1; num_next = M_NEXP; end
          else do_fail = 1'b1;
        end
        M_NEXPSIGN: begin
          if (dig) begin go_num = 1'b1; num_next = M_NEXP; end
          else do_fail = 1'b1;
        end
        M_NEXP: begin
          if (dig) begin go_num = 1'b1; num_next = M_NEXP; end
          else begin
            b = add_ev(b, EV_NUM_END, 8'd0); s.mode = M_AFTER; go_after = 1'b1;
          end
        end
        M_TRUE, M_FALSE, M_NULL: begin
          if (st_r.lpos >= llen || c != lit_char(st_r.mode, st_r.lpos)) do_fail = 1'b1;
          else begin
            s.lpos = st_r.lpos + 3'd1;
            if (s.lpos == llen) begin
              b = add_ev(b, (st_r.mode == M_TRUE) ? EV_TRUE :
                            ((st_r.mode == M_FALSE) ? EV_FALSE : EV_NULL), 8'd0);
              s.mode = M_AFTER;
            end
          end
        end
        M_SCH, M_KCH: begin
          if (c == "\"") begin
            b = add_ev(b, kmode ? EV_KEY_END : EV_STR_END, 8'd0);
            s.mode = kmode ? M_COLON : M_AFTER;
          end else if (c < 8'h20) do_fail = 1'b1;
          else if (c == "\\") s.mode = base + 5'd1;
          else b = add_ev(b, sev, c);
        end
        M_SESC, M_KESC: begin
          s.mode = base;
          case (c)
            "\"", "\\", "/": b = add_ev(b, sev, c);
            "b": b = add_ev(b, sev, 8'h08);
            "f": b = add_ev(b, sev, 8'h0C);
            "n": b = add_ev(b, sev, 8'h0A);
            "r": b = add_ev(b, sev, 8'h0D);
            "t": b = add_ev(b, sev, 8'h09);
            "u": begin
              s.mode = base + 5'd2; s.hcnt = 3'd0; s.hex = 16'd0;
            end
            default: do_fail = 1'b1;
          endcase
        end
        M_SHEX, M_KHEX: begin
          if (hv[4]) do_fail = 1'b1;
          else begin
            s.hex = hx;
            s.hcnt = st_r.hcnt + 3'd1;
            if (s.hcnt == 3'd4) begin
              if (hx >= 16'hD800 && hx <= 16'hDBFF) begin
                s.pend = hx[9:0]; s.hcnt = 3'd0; s.mode = base + 5'd3;
              end else if (hx >= 16'hDC00 && hx <= 16'hDFFF) do_fail = 1'b1;
              else begin
                go_utf = 1'b1; cp = 21'(hx); s.mode = base;
              end
            end
          end
        end
        M_SLOW, M_KLOW: begin
          if (st_r.hcnt == 3'd0) begin
            if (c == "\\") s.hcnt = 3'd1; else do_fail = 1'b1;
          end else if (st_r.hcnt == 3'd1) begin
            if (c == "u") begin s.hcnt = 3'd2; s.hex = 16'd0; end
            else do_fail = 1'b1;
          end else if (hv[4]) do_fail = 1'b1;
          else begin
            s.hex = hx;
            s.hcnt = st_r.hcnt + 3'd1;
            if (s.hcnt == 3'd6) begin
              if (hx < 16'hDC00 || hx > 16'hDFFF) do_fail = 1'b1;
              else begin
                go_utf = 1'b1;
                cp = 21'h10000 + {1'b0, st_r.pend, hx[9:0]};
                s.mode = base;
              end
            end
          end
        end
        default: do_fail = 1'b1;
      endcase

      // Start a value
      if (go_start) begin
        if ((CW'(dep_r) + CW'(1)) > lim) do_fail = 1'b1;
        else if (c == "{" || c == "[") begin
          push = 1'b1;
          dep = dep_r + DW'(1);
          b = add_ev(b, (c == "{") ? EV_OBJ_OPEN : EV_ARR_OPEN, 8'd0);
          s.mode = (c == "{") ? M_OBJ_FIRST : M_ARR_FIRST;
        end else if (c == "\"") s.mode = M_SCH;
        else if (c == "t" || c == "f" || c == "n") begin
          s.lpos = 3'd1;
          s.mode = (c == "t") ? M_TRUE : ((c == "f") ? M_FALSE : M_NULL);
        end else if (c == "-" || dig) begin
          s.nlen = 6'd0;
          go_num = 1'b1;
          num_next = (c == "-") ? M_NSIGN : ((c == "0") ? M_NZERO : M_NINT);
        end else do_fail = 1'b1;
      end

      // Take one number character
      if (go_num) begin
        if ((7'(s.nlen) + 7'd1) > 7'(maxn_r)) do_fail = 1'b1;
        else begin
          s.nlen = s.nlen + 6'd1;
          b = add_ev(b, EV_NUM_CHAR, c);
          s.mode = num_next;
        end
      end

      // Byte after a value
      if (go_after) begin
        if (ws) do_ws = 1'b1;
        else if (dep_r == '0) do_fail = 1'b1;
        else if (c == ",") s.mode = top_kind ? M_KEY_EXP : M_VALUE;
        else if (c == "]") begin go_close = 1'b1; close_kind = 1'b0; end
        else if (c == "}") begin go_close = 1'b1; close_kind = 1'b1; end
        else do_fail = 1'b1;
      end

      // Close a container
      if (go_close) begin
        if (dep_r == '0 || top_kind != close_kind) do_fail = 1'b1;
        else begin
          b = add_ev(b, close_kind ? EV_OBJ_CLOSE : EV_ARR_CLOSE, 8'd0);
          dep = dep_r - DW'(1);
          s.mode = M_AFTER;
        end
      end

      // Count newlines outside strings
      if (do_ws && c == 8'h0A && line_r != LINE_TOP) ln = line_r + LINE_BITS'(1);

      // Re-encode a code point as UTF-8
      if (go_utf) begin
        if (cp < 21'h80) b = add_ev(b, sev, cp[7:0]);
        else if (cp < 21'h800) begin
          b = add_ev(b, sev, 8'hC0 | 8'(cp >> 6));
          b = add_ev(b, sev, {2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
          b = add_ev(b, sev, 8'hE0 | 8'(cp >> 12));
          b = add_ev(b, sev, {2'b10, cp[11:6]});
          b = add_ev(b, sev, {2'b10, cp[5:0]});
        end else begin
          b = add_ev(b, sev, 8'hF0 | 8'(cp >> 18));
          b = add_ev(b, sev, {2'b10, cp[17:12]});
          b = add_ev(b, sev, {2'b10, cp[11:6]});
          b = add_ev(b, sev, {2'b10, cp[5:0]});
        end
      end

      if (do_fail) begin
        b = add_ev(b, EV_ERROR, 8'd0);
        s.mode = M_ERR;
      end

      // Close out the document
      if (end_of_text && s.mode != M_ERR) begin
        if (s.mode == M_NZERO || s.mode == M_NINT || s.mode == M_NFRAC ||
            s.mode == M_NEXP) begin
          b = add_ev(b, EV_NUM_END, 8'd0);
          s.mode = M_AFTER;
        end
        if (s.mode == M_AFTER && dep == '0) b = add_ev(b, EV_DONE, 8'd0);
        else begin
          b = add_ev(b, EV_ERROR, 8'd0);
          s.mode = M_ERR;
        end
      end
    end

    lw = 48'(ln);
    b.line = lw[15:0];

    // Fresh document after the end flag
    if (end_of_text) begin
      s = GST_RESET; dep = '0; ln = LINE_BITS'(1);
    end
    st_nxt = s; dep_nxt = dep; line_nxt = ln;
  end

  assign bundle = b;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= GST_RESET;
      dep_r   <= '0;
      line_r  <= LINE_BITS'(1);
      maxd_r  <= 7'd64;
      maxn_r  <= 6'd63;
      byp_r   <= 1'b0;
      bkind_r <= 1'b0;
    end else begin
      if (accept) begin
        st_r   <= st_nxt;
        dep_r  <= dep_nxt;
        line_r <= line_nxt;
      end
      byp_r   <= accept && push;
      bkind_r <= push_kind;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_MAX_DEPTH: maxd_r <= cfg_wdata;
          CFG_MAX_NLEN:  maxn_r <= cfg_wdata[5:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> sv/sjv_out.sv
module sjv_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sjv_pkg::bundle_t bundle,
  output logic             free,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,
  output logic             out_tlast
);
  import sjv_pkg::*;

  `include "strict_json_stream_validator_top_macros.svh"

  bundle_t    bund_r;
  logic       bv_r;
  logic [2:0] idx_r;
  logic       at_end;

  assign at_end     = (idx_r == bund_r.cnt - 3'd1);
  assign free       = !bv_r || (out_tready && at_end);
  assign out_tvalid = bv_r;
  assign out_tlast  = at_end;
  assign out_tdata  = {4'd0, bund_r.line, bund_r.data[idx_r], bund_r.ev[idx_r]};

  // Hold the bundle and step through its words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r  <= 1'b0;
      idx_r <= 3'd0;
    end else if (load) begin
      bv_r  <= 1'b1;
      idx_r <= 3'd0;
    end else if (bv_r && out_tready) begin
      if (at_end) bv_r <= 1'b0;
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bund_r <= bundle;
    end
  end

  `SJV_ASSERT_IMP(a_idx_in_range, bv_r, idx_r < bund_r.cnt)
  `SJV_ASSERT_IMP(a_load_when_free, load, free && bundle.cnt != 3'd0)
  `SJV_ASSERT_NXT(a_load_restarts, load, bv_r && idx_r == 3'd0)
  `SJV_ASSERT_NXT(a_stall_holds, bv_r && !out_tready && !load, $stable(idx_r) && bv_r)

endmodule

>>> sv/strict_json_stream_validator_top.sv
// The first word of a byte appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one word and
// out_tready is high; the output word buffer holds the input until a byte's last word is taken.
// Reset: synchronous, active-low rst_n; registers return to max_depth 64 and
// max_number_len 63, the grammar to its document start. No stack clearing pass.
module strict_json_stream_validator_top #(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [3:0] event_res, [11:4] data_byte, [27:12] line
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import sjv_pkg::*;

  bundle_t bundle;
  logic    accept;
  logic    free;

  assign in_tready = free;
  assign accept    = in_tvalid && free;
  assign cfg_ready = 1'b1;

  sjv_core #(.STACK_DEPTH(STACK_DEPTH), .LINE_BITS(LINE_BITS)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .byte_value  (in_tdata),
    .end_of_text (in_tlast),
    .cfg_we      (cfg_valid),
    .cfg_idx     (cfg_index),
    .cfg_wdata   (cfg_data),
    .bundle      (bundle)
  );

  sjv_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept && bundle.cnt != 3'd0),
    .bundle     (bundle),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
